[rtl/jwi_pkg.sv]
// Shared types, constants and codes of the joint waypoint interpolator.
package jwi_pkg;

    localparam int JOINTS          = 6;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MAX_BATCH_DEF   = 64;
    localparam int WRIST_FIRST     = 3;
    localparam int N_SAT           = 4095;
    localparam int N_W             = 12;
    localparam int POS_W           = 32;
    localparam int STEP_W          = 31;
    localparam int FILL_W          = 7;
    localparam int WORDS_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 31;

    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_REFILL = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_WRIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 2'd2;

    localparam logic [STEP_W-1:0]  STEP_BASE_RST  = 31'd217780;
    localparam logic [STEP_W-1:0]  STEP_WRIST_RST = 31'd260890;
    localparam logic [FILL_W-1:0]  TARGET_RST     = 7'd16;

    // command handed from the front end to the back end
    typedef struct packed {
        logic [1:0]         op;
        logic [5:0][31:0]   pos;
        logic               end_of_plan;
        logic [7:0]         need;   // saturated, 0 when nothing needed
    } jwi_cmd_t;

endpackage

[rtl/jwi_if.sv]
// Valid/ready channel interfaces for requests and waypoints.
interface jwi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] pos_0, pos_1, pos_2, pos_3, pos_4, pos_5;
    logic        end_of_plan;
    logic [15:0] buffer_words;
    modport source (output valid, op, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                    end_of_plan, buffer_words, input ready);
    modport sink (input valid, op, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                  end_of_plan, buffer_words, output ready);
endinterface

interface jwi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] way_0, way_1, way_2, way_3, way_4, way_5;
    logic        last_of_batch;
    modport source (output valid, way_0, way_1, way_2, way_3, way_4, way_5,
                    last_of_batch, input ready);
    modport sink (input valid, way_0, way_1, way_2, way_3, way_4, way_5,
                  last_of_batch, output ready);
endinterface

[rtl/jwi_front.sv]
// Front end: takes requests, works out the refill need, queues commands.
module jwi_front
    import jwi_pkg::*;
#(
    parameter int MAX_BATCH = MAX_BATCH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    jwi_in_if.sink            in_ch,
    input  logic [FILL_W-1:0] target_fill,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output jwi_cmd_t          cmd
);
    localparam int FQ = 2;

    jwi_cmd_t  fifo_reg [FQ];
    logic      wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [14:0] held;
    logic signed [16:0] need_s;
    jwi_cmd_t  c;
    logic      push, pop;

    // ceil(words/6): multiply by reciprocal of 6 (43691/2^18), exact for 17 bits
    logic [16:0] wp5;
    logic [33:0] prod;
    always_comb
    begin
        wp5    = {1'b0, in_ch.buffer_words} + 17'd5;
        prod   = {17'd0, wp5} * 34'd43691;
        held   = prod[32:18];
        need_s = $signed({10'd0, target_fill}) - $signed({2'b0, held});
        c.op   = in_ch.op;
        c.pos  = {in_ch.pos_5, in_ch.pos_4, in_ch.pos_3,
                  in_ch.pos_2, in_ch.pos_1, in_ch.pos_0};
        c.end_of_plan = in_ch.end_of_plan;
        if (need_s <= 0)
            c.need = 8'd0;
        else if (need_s > MAX_BATCH)
            c.need = 8'(MAX_BATCH);
        else
            c.need = need_s[7:0];
    end

    assign in_ch.ready = (cnt_reg != 2'(FQ));
    assign push = in_ch.valid && in_ch.ready && (in_ch.op != OP_UNUSED);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop  = cmd_valid && cmd_ready;
    assign cmd  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

[rtl/jwi_div.sv]
// Iterative restoring divider, one quotient bit a cycle, unsigned operands.
module jwi_div
    import jwi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [44:0] num,      // magnitude of dividend
    input  logic [31:0] den,
    output logic        done,
    output logic [44:0] quo       // magnitude quotient
);
    logic [44:0] q_reg;
    logic [32:0] r_reg;
    logic [5:0]  i_reg;
    logic        busy_reg, done_reg;
    logic [31:0] d_reg;
    logic [32:0] rs;
    logic [33:0] diff;

    always_comb
    begin
        rs   = {r_reg[31:0], q_reg[44]};
        diff = {1'b0, rs} - {2'b0, d_reg};
    end

    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= 6'd0;
            end
            else if (busy_reg)
            begin
                if (i_reg == 6'd44)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            r_reg   <= 33'd0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                r_reg <= diff[32:0];
                q_reg <= {q_reg[43:0], 1'b1};
            end
            else
            begin
                r_reg <= rs;
                q_reg <= {q_reg[43:0], 1'b0};
            end
        end
    end
endmodule

[rtl/jwi_back.sv]
// Back end: point queue, segment count and linear interpolation sequencer.
module jwi_back
    import jwi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  jwi_cmd_t          cmd,
    input  logic [STEP_W-1:0] max_step_base,
    input  logic [STEP_W-1:0] max_step_wrist,
    jwi_out_if.source         out_ch
);
    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int JA = $clog2(JOINTS + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2,
        S_NJ = 4'd3, S_NW = 4'd4, S_PJ = 4'd5, S_PW = 4'd6, S_EMIT = 4'd7,
        S_OUT = 4'd8;

    logic [3:0]  st_reg;
    logic [POS_W*6-1:0] mem [QUEUE_DEPTH];
    logic [POS_W*6-1:0] rd_reg;
    logic [QA:0]  qcount_reg;
    logic [QA-1:0] qhead_reg;
    logic [5:0][31:0] last_reg, pre_reg, base_reg, tgt_reg, way_reg, out_way_reg;
    logic [63:0] batch_reg, tag_reg;
    logic [7:0]  need_reg;
    logic [N_W-1:0] n_reg, k_reg;
    logic [JA-1:0] j_reg;
    logic        seg_reg, last_out_reg, ovalid_reg;

    logic        div_start, div_done;
    logic [44:0] div_num, div_q;
    logic [31:0] div_den;

    jwi_div u_div (.clk, .rst_n, .start(div_start), .num(div_num),
                   .den(div_den), .done(div_done), .quo(div_q));

    // per-joint arithmetic for the joint selected by j_reg
    logic [2:0]  js;
    logic signed [32:0] d;
    logic [32:0] mag;
    logic [30:0] stp;
    logic signed [45:0] prodk;
    logic [44:0] pmag;
    logic signed [45:0] sq;
    logic [QA:0]   wsum;
    logic [QA-1:0] wslot;
    always_comb
    begin
        js   = 3'(j_reg);
        d    = $signed({tgt_reg[js][31], tgt_reg[js]})
             - $signed({base_reg[js][31], base_reg[js]});
        mag  = d[32] ? 33'(-d) : 33'(d);
        stp  = (js < 3'(WRIST_FIRST)) ? max_step_base : max_step_wrist;
        if (stp == 31'd0)
            stp = 31'd1;
        prodk = d * $signed({1'b0, k_reg + N_W'(1)});
        pmag  = prodk[45] ? 45'(-prodk) : 45'(prodk);
        sq    = prodk[45] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        // tail slot wraps at the queue depth
        wsum  = {1'b0, qhead_reg} + qcount_reg;
        if (wsum >= (QA+1)'(QUEUE_DEPTH))
            wslot = QA'(wsum - (QA+1)'(QUEUE_DEPTH));
        else
            wslot = QA'(wsum);
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = {1'b0, stp};
        if (st_reg == S_NJ)
        begin
            div_start = 1'b1;
            div_num   = 45'(mag) + 45'(stp) - 45'd1;
        end
        else if (st_reg == S_PJ)
        begin
            div_start = 1'b1;
            div_num   = pmag;
            div_den   = 32'(n_reg);
        end
    end

    assign cmd_ready = (st_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.way_0 = out_way_reg[0];
    assign out_ch.way_1 = out_way_reg[1];
    assign out_ch.way_2 = out_way_reg[2];
    assign out_ch.way_3 = out_way_reg[3];
    assign out_ch.way_4 = out_way_reg[4];
    assign out_ch.way_5 = out_way_reg[5];
    assign out_ch.last_of_batch = last_out_reg;

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && cmd_valid && cmd.op == OP_PUSH
            && qcount_reg < (QA+1)'(QUEUE_DEPTH))
            mem[wslot] <= cmd.pos;
        rd_reg <= mem[qhead_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            qcount_reg <= '0;
            qhead_reg <= '0;
            last_reg <= '0;
            batch_reg <= '0;
            tag_reg <= '0;
            ovalid_reg <= 1'b0;
            need_reg <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            OP_PUSH:
                            begin
                                if (qcount_reg < (QA+1)'(QUEUE_DEPTH))
                                    qcount_reg <= qcount_reg + 1'b1;
                                if (cmd.end_of_plan)
                                    tag_reg <= batch_reg;
                            end
                            OP_LOAD: last_reg <= cmd.pos;
                            OP_REFILL:
                            begin
                                if (tag_reg != batch_reg)
                                begin
                                    qcount_reg <= '0;
                                    qhead_reg  <= '0;
                                end
                                need_reg <= cmd.need;
                                pre_reg  <= last_reg;
                                seg_reg  <= 1'b0;
                                if (cmd.need != 8'd0)
                                    st_reg <= S_RD;
                            end
                            default: ;
                        endcase
                    end
                S_RD:
                begin
                    if (need_reg == 8'd0)
                    begin
                        last_reg  <= pre_reg;
                        batch_reg <= batch_reg + 64'd1;
                        st_reg    <= S_IDLE;
                    end
                    else if (qcount_reg == '0)
                    begin
                        way_reg <= pre_reg;
                        st_reg  <= S_EMIT;
                    end
                    else if (seg_reg)
                    begin
                        j_reg  <= '0;
                        st_reg <= S_PJ;
                    end
                    else
                        st_reg <= S_RDW;
                end
                S_RDW:
                begin
                    tgt_reg  <= rd_reg;
                    base_reg <= pre_reg;
                    n_reg    <= N_W'(1);
                    k_reg    <= '0;
                    j_reg    <= '0;
                    seg_reg  <= 1'b1;
                    st_reg   <= S_NJ;
                end
                S_NJ: st_reg <= S_NW;
                S_NW:
                    if (div_done)
                    begin
                        if (div_q > 45'(N_SAT))
                            n_reg <= N_W'(N_SAT);
                        else if (div_q[N_W-1:0] > n_reg)
                            n_reg <= div_q[N_W-1:0];
                        if (j_reg == JA'(JOINTS-1))
                        begin
                            j_reg  <= '0;
                            st_reg <= S_PJ;
                        end
                        else
                        begin
                            j_reg  <= j_reg + 1'b1;
                            st_reg <= S_NJ;
                        end
                    end
                S_PJ: st_reg <= S_PW;
                S_PW:
                    if (div_done)
                    begin
                        way_reg[js] <= 32'($signed({base_reg[js][31], base_reg[js]}) + sq);
                        if (j_reg == JA'(JOINTS-1))
                            st_reg <= S_EMIT;
                        else
                        begin
                            j_reg  <= j_reg + 1'b1;
                            st_reg <= S_PJ;
                        end
                    end
                S_EMIT:
                    if (!ovalid_reg)
                    begin
                        ovalid_reg   <= 1'b1;
                        out_way_reg  <= way_reg;
                        last_out_reg <= (need_reg == 8'd1);
                        pre_reg      <= way_reg;
                        need_reg     <= need_reg - 8'd1;
                        if (qcount_reg != '0)
                        begin
                            if (k_reg == n_reg - N_W'(1))
                            begin
                                if (qhead_reg == QA'(QUEUE_DEPTH - 1))
                                    qhead_reg <= '0;
                                else
                                    qhead_reg <= qhead_reg + 1'b1;
                                qcount_reg <= qcount_reg - 1'b1;
                                seg_reg    <= 1'b0;
                            end
                            k_reg <= k_reg + N_W'(1);
                        end
                        st_reg <= S_OUT;
                    end
                S_OUT: st_reg <= S_RD;   // lets the queue head read settle
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/joint_waypoint_interpolator.sv]
// Channel   | Dir | Carries
// in_ch     | in  | push, refill and load requests with six joint angles
// out_ch    | out | waypoints, last_of_batch on the final one of a refill
// cfg       | in  | step limits and fill target, write only
// Push and load pass the front queue, then take effect in the sequencer.
// A refill repeats the last point while the queue is empty; else it does one
// division per joint per point, plus one per joint where a segment starts.
// Reset empties the queue, clears the last point and batch counters.
// A stalled output holds the sequencer at its next waypoint; the two-entry
// front queue takes up to two more requests meanwhile.
module joint_waypoint_interpolator
    import jwi_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_BATCH   = MAX_BATCH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    jwi_in_if.sink                in_ch,
    jwi_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    logic [STEP_W-1:0] step_base_reg, step_wrist_reg;
    logic [FILL_W-1:0] target_reg;
    logic     cmd_valid, cmd_ready;
    jwi_cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_base_reg  <= STEP_BASE_RST;
            step_wrist_reg <= STEP_WRIST_RST;
            target_reg     <= TARGET_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_STEP_BASE:  step_base_reg  <= cfg_data;
                REG_STEP_WRIST: step_wrist_reg <= cfg_data;
                REG_TARGET:     target_reg     <= cfg_data[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    jwi_front #(.MAX_BATCH(MAX_BATCH)) u_front (
        .clk, .rst_n, .in_ch, .target_fill(target_reg),
        .cmd_valid, .cmd_ready, .cmd);

    jwi_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
        .max_step_base(step_base_reg), .max_step_wrist(step_wrist_reg), .out_ch);

`ifndef SYNTHESIS
    a_cmd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !out_ch.valid || !out_ch.last_of_batch || out_ch.ready
                      || $past(out_ch.valid))
        else $error("sequencer idle with batch tail");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.way_0))
        else $error("waypoint dropped");
`endif
endmodule

[dv/tb.sv]
// Self-checking testbench of the joint waypoint interpolator: random bursts, stalls and phases.
module tb;
    import jwi_pkg::*;

    typedef struct {
        logic [1:0]       op;
        logic [5:0][31:0] pos;
        logic             eop;
        logic [15:0]      words;
    } request_t;

    typedef struct {
        logic [5:0][31:0] way;
        logic             last;
    } waypoint_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    jwi_in_if  in_ch();
    jwi_out_if out_ch();

    joint_waypoint_interpolator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    request_t  request_fifo[$];
    waypoint_t pending_waypoints[$];

    // shadow of the block's state and registers
    logic [30:0]      step_base;
    logic [30:0]      step_wrist;
    logic [6:0]       fill_target;
    logic [5:0][31:0] plan_queue[64];
    int               plan_count = 0;
    int               plan_head = 0;
    logic [5:0][31:0] last_sent = '0;
    logic [63:0]      batch_cnt = '0;
    logic [63:0]      plan_tag = '0;

    int mismatches = 0;
    int idle_cycles;
    logic [5:0][31:0] walk_pt;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint unsigned step_wrist_or_base(bit wrist);
        return wrist ? longint'(step_wrist) : longint'(step_base);
    endfunction

    function automatic longint seg_steps(logic [5:0][31:0] from, logic [5:0][31:0] to);
        longint unsigned n;
        longint d;
        longint unsigned mag;
        longint unsigned s;
        longint unsigned c;
        n = 1;
        for (int j = 0; j < 6; j++)
        begin
            d = longint'($signed(to[j])) - longint'($signed(from[j]));
            mag = (d < 0) ? -d : d;
            s = (j < WRIST_FIRST) ? step_wrist_or_base(0) : step_wrist_or_base(1);
            if (s == 0)
                s = 1;
            c = (mag + s - 1) / s;
            if (c > n)
                n = c;
        end
        if (n > N_SAT)
            n = N_SAT;
        return longint'(n);
    endfunction

    task automatic predict_waypoints(request_t r);
        int held;
        int need;
        int emitted;
        longint n;
        longint d;
        longint v;
        logic [5:0][31:0] pre;
        logic [5:0][31:0] base;
        logic [5:0][31:0] tgt;
        waypoint_t w;
        if (r.op == OP_PUSH)
        begin
            if (plan_count < 64)
            begin
                plan_queue[(plan_head + plan_count) % 64] = r.pos;
                plan_count++;
            end
            if (r.eop)
                plan_tag = batch_cnt;
        end
        else if (r.op == OP_LOAD)
            last_sent = r.pos;
        else if (r.op == OP_REFILL)
        begin
            held = (int'(r.words) + 5) / 6;
            need = int'(fill_target) - held;
            emitted = 0;
            if (plan_tag != batch_cnt)
            begin
                plan_count = 0;
                plan_head = 0;
            end
            if (need > 0)
            begin
                if (need > MAX_BATCH_DEF)
                    need = MAX_BATCH_DEF;
                pre = last_sent;
                while (need > 0)
                begin
                    if (plan_count == 0)
                    begin
                        w.way = pre;
                        w.last = (need == 1);
                        pending_waypoints.insert(pending_waypoints.size(), w);
                        need--;
                    end
                    else
                    begin
                        tgt = plan_queue[plan_head];
                        n = seg_steps(pre, tgt);
                        base = pre;
                        for (longint k = 0; k < n && need > 0; k++)
                        begin
                            for (int j = 0; j < 6; j++)
                            begin
                                d = longint'($signed(tgt[j])) - longint'($signed(base[j]));
                                v = longint'($signed(base[j])) + (d * (k + 1)) / n;
                                pre[j] = v[31:0];
                            end
                            w.way = pre;
                            w.last = (need == 1);
                            pending_waypoints.insert(pending_waypoints.size(), w);
                            need--;
                            if (k == n - 1)
                            begin
                                plan_head = (plan_head + 1) % 64;
                                plan_count--;
                            end
                        end
                    end
                end
                last_sent = pre;
                batch_cnt++;
            end
        end
    endtask

    // driver: bursts of requests with gaps between them
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.op <= OP_PUSH;
            in_ch.pos_0 <= '0;
            in_ch.pos_1 <= '0;
            in_ch.pos_2 <= '0;
            in_ch.pos_3 <= '0;
            in_ch.pos_4 <= '0;
            in_ch.pos_5 <= '0;
            in_ch.end_of_plan <= 1'b0;
            in_ch.buffer_words <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else if (!(in_ch.valid && !in_ch.ready))
        begin
            if (gap_left > 0)
            begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_fifo.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.op <= request_fifo[0].op;
                in_ch.pos_0 <= request_fifo[0].pos[0];
                in_ch.pos_1 <= request_fifo[0].pos[1];
                in_ch.pos_2 <= request_fifo[0].pos[2];
                in_ch.pos_3 <= request_fifo[0].pos[3];
                in_ch.pos_4 <= request_fifo[0].pos[4];
                in_ch.pos_5 <= request_fifo[0].pos[5];
                in_ch.end_of_plan <= request_fifo[0].eop;
                in_ch.buffer_words <= request_fifo[0].words;
                request_fifo.delete(0);
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver stall pattern; stall_cnt sets when stall_mode is redrawn at random
    int stall_cnt;
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_cnt <= 0;
            stall_mode <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 64 == 63)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= (stall_cnt % 8) > 2;
                default: out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // request monitor feeds the predictor; waypoint monitor checks
    always @(posedge clk)
    begin
        request_t r;
        waypoint_t got;
        waypoint_t exp_w;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            r.op = in_ch.op;
            r.pos = {in_ch.pos_5, in_ch.pos_4, in_ch.pos_3,
                     in_ch.pos_2, in_ch.pos_1, in_ch.pos_0};
            r.eop = in_ch.end_of_plan;
            r.words = in_ch.buffer_words;
            predict_waypoints(r);
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.way = {out_ch.way_5, out_ch.way_4, out_ch.way_3,
                       out_ch.way_2, out_ch.way_1, out_ch.way_0};
            got.last = out_ch.last_of_batch;
            if (pending_waypoints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected waypoint %h last %b", got.way, got.last);
            end
            else
            begin
                exp_w = pending_waypoints[0];
                pending_waypoints.delete(0);
                if (got.way !== exp_w.way || got.last !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("waypoint mismatch: exp %h last %b, got %h last %b",
                                 exp_w.way, exp_w.last, got.way, got.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 40000)
        begin
            $display("** joint_waypoint_interpolator: FAILED **");
            $finish;
        end
    end

    task automatic add_request(logic [1:0] op, logic [5:0][31:0] pos, logic eop,
                               logic [15:0] words);
        request_t r;
        r.op = op;
        r.pos = pos;
        r.eop = eop;
        r.words = words;
        request_fifo.insert(request_fifo.size(), r);
    endtask

    function automatic logic [5:0][31:0] random_point();
        logic [5:0][31:0] p;
        for (int j = 0; j < 6; j++)
            p[j] = $urandom;
        return p;
    endfunction

    function automatic logic [5:0][31:0] near_point(logic [5:0][31:0] p, int spread);
        logic [5:0][31:0] q;
        for (int j = 0; j < 6; j++)
            q[j] = p[j] + $urandom_range(0, 2 * spread) - spread;
        return q;
    endfunction

    function automatic logic [15:0] random_words();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100));
    endfunction

    // mostly plans of a few points then refills; the rest is noise and broken plans
    task automatic add_random(int count);
        int added;
        int pts;
        added = 0;
        while (added < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    if ($urandom_range(0, 2) == 0)
                    begin
                        walk_pt = ($urandom_range(0, 3) == 0) ? random_point() : walk_pt;
                        add_request(OP_LOAD, walk_pt, 1'($urandom_range(0, 1)), 16'($urandom));
                        added++;
                    end
                    pts = $urandom_range(1, 4);
                    for (int i = 0; i < pts; i++)
                    begin
                        walk_pt = near_point(walk_pt, $urandom_range(0, 1) ? 1000000 : 3000);
                        add_request(OP_PUSH, walk_pt, i == pts - 1, 16'($urandom));
                    end
                    added += pts;
                    add_request(OP_REFILL, random_point(), 1'($urandom_range(0, 1)),
                                random_words());
                    added++;
                end
                6:
                begin
                    add_request(OP_REFILL, random_point(), 1'($urandom_range(0, 1)),
                                random_words());
                    added++;
                end
                7:
                begin
                    walk_pt = near_point(walk_pt, 500000);
                    add_request(OP_PUSH, walk_pt, 1'b0, 16'($urandom));
                    add_request(OP_REFILL, random_point(), 1'b0, random_words());
                    added += 2;
                end
                default:
                begin
                    add_request($urandom_range(0, 1) ? OP_UNUSED : 2'($urandom_range(0, 3)),
                                random_point(), 1'($urandom_range(0, 1)), random_words());
                    added++;
                end
            endcase
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_BASE:  step_base = data;
            REG_STEP_WRIST: step_wrist = data;
            default:        fill_target = data[6:0];
        endcase
    endtask

    task automatic drain();
        while (request_fifo.size() > 0 || in_ch.valid || pending_waypoints.size() > 0)
            @(posedge clk);
        // a refill that emits nothing may still be in flight
        repeat (800) @(posedge clk);
    endtask

    task automatic set_phase(logic [30:0] sb, logic [30:0] sw, logic [6:0] tf);
        drain();
        write_reg(REG_STEP_BASE, sb);
        write_reg(REG_STEP_WRIST, sw);
        write_reg(REG_TARGET, {24'd0, tf});
    endtask

    initial
    begin
        logic [5:0][31:0] p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        step_base = STEP_BASE_RST;
        step_wrist = STEP_WRIST_RST;
        fill_target = TARGET_RST;
        walk_pt = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue repeats the reset point, then extremes of the angles
        add_request(OP_REFILL, '0, 1'b0, 16'd0);
        p = {6{32'h7FFF_FFFF}};
        add_request(OP_PUSH, p, 1'b1, 16'hFFFF);
        add_request(OP_LOAD, {6{32'h8000_0000}}, 1'b1, 16'hFFFF);
        add_request(OP_REFILL, p, 1'b1, 16'd90);
        add_request(OP_REFILL, p, 1'b0, 16'd89);
        add_request(OP_REFILL, '0, 1'b0, 16'hFFFF);
        add_request(OP_UNUSED, p, 1'b1, 16'd0);
        // plan without its end mark goes stale and is flushed
        add_request(OP_PUSH, '0, 1'b0, 16'd0);
        add_request(OP_REFILL, '0, 1'b0, 16'd0);
        add_request(OP_LOAD, '0, 1'b0, 16'd0);
        add_request(OP_PUSH, {32'd3000000, 32'hFFD0_0000, 32'd1, 32'd0, 32'd500000, 32'd7},
                    1'b1, 16'd0);
        add_request(OP_REFILL, '0, 1'b0, 16'd85);
        add_request(OP_REFILL, '0, 1'b0, 16'd60);
        add_random(40);

        // full queue: late points are dropped
        set_phase(31'd50000, 31'd70000, 7'd12);
        for (int i = 0; i < 66; i++)
        begin
            walk_pt = near_point(walk_pt, 60000);
            add_request(OP_PUSH, walk_pt, i == 65, 16'($urandom));
        end
        add_request(OP_REFILL, '0, 1'b0, 16'd0);
        add_request(OP_REFILL, '0, 1'b0, 16'd30);

        set_phase(31'd1, 31'd1, 7'd64);
        add_random(18);
        set_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 7'd0);
        add_random(30);
        set_phase(31'd0, 31'd0, 7'd8);
        add_random(40);
        set_phase(31'($urandom_range(1000, 2000000)), 31'($urandom_range(1000, 2000000)),
                  7'($urandom_range(1, 20)));
        add_random(25);
        drain();

        if (mismatches == 0 && pending_waypoints.size() == 0)
            $display("** joint_waypoint_interpolator: PASSED **");
        else
            $display("** joint_waypoint_interpolator: FAILED **");
        $finish;
    end
endmodule
